// ===== src/assert_macros.svh =====
// Assertion macros included by the text console RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tcw_pkg.sv =====
// Types and constants of the text console cell writer.
package tcw_pkg;

  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 24;

  localparam logic [COLOR_W-1:0] FILL_RESET = 24'hAAAAAA;

  localparam logic [CHAR_W-1:0] CODE_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_NL  = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_CR  = 8'd13;

  typedef enum logic [1:0] {
    CMD_PUT_CHAR = 2'd0,
    CMD_CLEAR    = 2'd1,
    CMD_READ     = 2'd2,
    CMD_MOVE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_CLEAR,
    S_RESP
  } state_t;

endpackage

// ===== src/text_console_cell_writer.sv =====
// Text console: character/color stores, cursor, scroll and clear sequencer.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-------------------------------------
//  in      | input     | in_valid / in_ready  | cmd, char_code, color, col, row
//  out     | output    | out_valid / out_ready| cursor_col, cursor_row, line_advanced,
//          |           |                      | cell_char, cell_color
//  cfg     | input     | cfg_wen              | cfg_wdata (scroll fill color)
//
// Each word takes an execute step against the cell RAMs, then a result step that loads the output.
// A line advance (newline, tab or wrap) on the last row adds a sweep: the rows are a ring, and the exposed row
// is refilled one cell per cycle through the single write port. clear_screen adds a sweep
// over every character cell, one character cell per cycle.
// After rst an init pass fills both RAMs; in_ready stays low.
// A result held by out_ready low stalls the next word in the result cycle.
`include "assert_macros.svh"

module text_console_cell_writer #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 4,
  localparam int COL_W   = $clog2(COLUMNS),
  localparam int ROW_W   = $clog2(ROWS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcw_pkg::COLOR_W-1:0]  color,
  input  logic [COL_W-1:0]             col,
  input  logic [ROW_W-1:0]             row,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [COL_W-1:0]             cursor_col,
  output logic [ROW_W-1:0]             cursor_row,
  output logic                         line_advanced,
  output logic [tcw_pkg::CHAR_W-1:0]   cell_char,
  output logic [tcw_pkg::COLOR_W-1:0]  cell_color,
  input  logic                         cfg_wen,
  input  logic [tcw_pkg::COLOR_W-1:0]  cfg_wdata
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int AW1    = ADDR_W + 1;
  localparam int CW1    = COL_W + 1;
  localparam int RW1    = ROW_W + 1;
  localparam int TAB_W  = $clog2((2 ** COL_W) + TAB_STOP);

  localparam logic [COL_W-1:0]  COL_LAST       = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST       = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST      = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_START_LAST = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_SPAN       = ADDR_W'(COLUMNS);

  // cell RAMs
  logic [tcw_pkg::CHAR_W-1:0]  char_mem  [CELLS];
  logic [tcw_pkg::COLOR_W-1:0] color_mem [CELLS];

  tcw_pkg::state_t state, state_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [ADDR_W-1:0] top_addr, top_addr_next;   // RAM address of screen row 0
  logic [ADDR_W-1:0] row_addr, row_addr_next;   // RAM address of cursor row
  logic [ADDR_W-1:0] sweep_addr, sweep_addr_next;
  logic [ADDR_W-1:0] sweep_last, sweep_last_next;
  logic [tcw_pkg::COLOR_W-1:0] fill_color;
  logic out_valid_next;

  tcw_pkg::cmd_t req_cmd;
  logic [tcw_pkg::CHAR_W-1:0]  req_char;
  logic [tcw_pkg::COLOR_W-1:0] req_color;
  logic [COL_W-1:0]            req_col;
  logic [ROW_W-1:0]            req_row;
  logic adv, adv_next;

  logic                        char_we, color_we, rd_en;
  logic [ADDR_W-1:0]           wr_addr, rd_addr;
  logic [tcw_pkg::CHAR_W-1:0]  wr_char, rd_char;
  logic [tcw_pkg::COLOR_W-1:0] wr_color, rd_color;

  logic take, load_out, slot_free, do_nl;
  logic [CW1-1:0]    col_inc;
  logic [TAB_W-1:0]  tab_nc;
  logic [TAB_W-1:0]  tab_tbl [2 ** COL_W];
  logic [ADDR_W-1:0] row_addr_chk;

  function automatic logic [COL_W-1:0] clamp_col(input logic [COL_W-1:0] c);
    if ({1'b0, c} >= CW1'(COLUMNS)) return COL_LAST;
    return c;
  endfunction

  function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] r);
    if ({1'b0, r} >= RW1'(ROWS)) return ROW_LAST;
    return r;
  endfunction

  // RAM address of screen row r, rows kept as a ring starting at top
  function automatic logic [ADDR_W-1:0] row_start(input logic [ADDR_W-1:0] top,
                                                  input logic [ROW_W-1:0] r);
    logic [AW1-1:0] sum;
    sum = {1'b0, top} + AW1'(r) * AW1'(COLUMNS);
    if (sum >= AW1'(CELLS)) sum = sum - AW1'(CELLS);
    return sum[ADDR_W-1:0];
  endfunction

  // next tab stop per column, fixed at elaboration
  for (genvar g = 0; g < 2 ** COL_W; g++) begin : g_tab
    assign tab_tbl[g] = TAB_W'(((g / TAB_STOP) + 1) * TAB_STOP);
  end

  assign tab_nc       = tab_tbl[cur_col];
  assign col_inc      = {1'b0, cur_col} + CW1'(1);
  assign slot_free    = !out_valid || out_ready;
  assign row_addr_chk = row_start(top_addr, cur_row);
  assign rd_addr      = row_start(top_addr, clamp_row(req_row)) + ADDR_W'(clamp_col(req_col));

  always_comb begin
    state_next      = state;
    cur_col_next    = cur_col;
    cur_row_next    = cur_row;
    top_addr_next   = top_addr;
    row_addr_next   = row_addr;
    sweep_addr_next = sweep_addr;
    sweep_last_next = sweep_last;
    adv_next        = adv;
    in_ready        = 1'b0;
    load_out        = 1'b0;
    char_we         = 1'b0;
    color_we        = 1'b0;
    rd_en           = 1'b0;
    wr_addr         = sweep_addr;
    wr_char         = '0;
    wr_color        = fill_color;
    do_nl           = 1'b0;

    case (state)
      tcw_pkg::S_INIT: begin
        char_we         = 1'b1;
        color_we        = 1'b1;
        wr_color        = tcw_pkg::FILL_RESET;
        sweep_addr_next = sweep_addr + ADDR_W'(1);
        if (sweep_addr == sweep_last) state_next = tcw_pkg::S_IDLE;
      end
      tcw_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      tcw_pkg::S_EXEC: begin
        state_next = tcw_pkg::S_RESP;
        case (req_cmd)
          tcw_pkg::CMD_PUT_CHAR: begin
            case (req_char)
              tcw_pkg::CODE_NL: do_nl = 1'b1;
              tcw_pkg::CODE_TAB: begin
                if (tab_nc >= TAB_W'(COLUMNS)) do_nl = 1'b1;
                else cur_col_next = tab_nc[COL_W-1:0];
              end
              tcw_pkg::CODE_CR: cur_col_next = '0;
              tcw_pkg::CODE_BS: begin
                if (cur_col != '0) begin
                  cur_col_next = cur_col - COL_W'(1);
                  char_we      = 1'b1;
                  wr_addr      = row_addr + ADDR_W'(cur_col) - ADDR_W'(1);
                  wr_char      = '0;
                end
              end
              default: begin
                char_we  = 1'b1;
                color_we = 1'b1;
                wr_addr  = row_addr + ADDR_W'(cur_col);
                wr_char  = req_char;
                wr_color = req_color;
                if (col_inc >= CW1'(COLUMNS)) do_nl = 1'b1;
                else cur_col_next = col_inc[COL_W-1:0];
              end
            endcase
          end
          tcw_pkg::CMD_CLEAR: begin
            cur_col_next    = '0;
            cur_row_next    = '0;
            row_addr_next   = top_addr;
            sweep_addr_next = '0;
            sweep_last_next = CELL_LAST;
            state_next      = tcw_pkg::S_CLEAR;
          end
          tcw_pkg::CMD_READ: rd_en = 1'b1;
          tcw_pkg::CMD_MOVE: begin
            cur_col_next  = clamp_col(req_col);
            cur_row_next  = clamp_row(req_row);
            row_addr_next = row_start(top_addr, clamp_row(req_row));
          end
          default: ;
        endcase
        adv_next = do_nl;
        if (do_nl) begin
          cur_col_next = '0;
          if (cur_row == ROW_LAST) begin
            // scroll: old top row becomes the new bottom row, refilled below
            sweep_addr_next = top_addr;
            sweep_last_next = top_addr + ROW_SPAN - ADDR_W'(1);
            row_addr_next   = top_addr;
            top_addr_next   = (top_addr == ROW_START_LAST) ? '0 : top_addr + ROW_SPAN;
            state_next      = tcw_pkg::S_SCROLL;
          end else begin
            cur_row_next  = cur_row + ROW_W'(1);
            row_addr_next = (row_addr == ROW_START_LAST) ? '0 : row_addr + ROW_SPAN;
          end
        end
      end
      tcw_pkg::S_SCROLL: begin
        char_we         = 1'b1;
        color_we        = 1'b1;
        sweep_addr_next = sweep_addr + ADDR_W'(1);
        if (sweep_addr == sweep_last) state_next = tcw_pkg::S_RESP;
      end
      tcw_pkg::S_CLEAR: begin
        char_we         = 1'b1;
        sweep_addr_next = sweep_addr + ADDR_W'(1);
        if (sweep_addr == sweep_last) state_next = tcw_pkg::S_RESP;
      end
      tcw_pkg::S_RESP: begin
        if (slot_free) begin
          load_out   = 1'b1;
          in_ready   = 1'b1;
          state_next = tcw_pkg::S_IDLE;
        end
      end
      default: state_next = tcw_pkg::S_IDLE;
    endcase

    take = in_valid && in_ready;
    if (take) state_next = tcw_pkg::S_EXEC;

    if (load_out) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tcw_pkg::S_INIT;
      cur_col    <= '0;
      cur_row    <= '0;
      top_addr   <= '0;
      row_addr   <= '0;
      sweep_addr <= '0;
      sweep_last <= CELL_LAST;
      out_valid  <= 1'b0;
      fill_color <= tcw_pkg::FILL_RESET;
    end else begin
      state      <= state_next;
      cur_col    <= cur_col_next;
      cur_row    <= cur_row_next;
      top_addr   <= top_addr_next;
      row_addr   <= row_addr_next;
      sweep_addr <= sweep_addr_next;
      sweep_last <= sweep_last_next;
      out_valid  <= out_valid_next;
      if (cfg_wen) fill_color <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    adv <= adv_next;
    if (take) begin
      req_cmd   <= tcw_pkg::cmd_t'(cmd);
      req_char  <= char_code;
      req_color <= color;
      req_col   <= col;
      req_row   <= row;
    end
    if (load_out) begin
      cursor_col    <= cur_col;
      cursor_row    <= cur_row;
      line_advanced <= adv;
      cell_char     <= (req_cmd == tcw_pkg::CMD_READ) ? rd_char : '0;
      cell_color    <= (req_cmd == tcw_pkg::CMD_READ) ? rd_color : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_we) char_mem[wr_addr] <= wr_char;
    if (rd_en) rd_char <= char_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (color_we) color_mem[wr_addr] <= wr_color;
    if (rd_en) rd_color <= color_mem[rd_addr];
  end

  `ASSERT_ALWAYS(a_cursor_range, clk, rst, ({1'b0, cur_col} < CW1'(COLUMNS)) && ({1'b0, cur_row} < RW1'(ROWS)), "cursor off screen")
  `ASSERT_ALWAYS(a_row_addr, clk, rst, row_addr == row_addr_chk, "cursor row address out of step with ring")
  `ASSERT_ALWAYS(a_top_range, clk, rst, top_addr <= ROW_START_LAST, "ring top past last row start")
  `ASSERT_NEXT(a_resp_hold, clk, rst, (state == tcw_pkg::S_RESP) && out_valid && !out_ready, state == tcw_pkg::S_RESP, "result dropped while output stalled")

endmodule

// ===== sim/tcw_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the text console: tracks cells and cursor, checks every result word.
module tcw_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [1:0]                   cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcw_pkg::COLOR_W-1:0]  color,
  input  logic [6:0]                   col,
  input  logic [4:0]                   row,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [6:0]                   cursor_col,
  input  logic [4:0]                   cursor_row,
  input  logic                         line_advanced,
  input  logic [tcw_pkg::CHAR_W-1:0]   cell_char,
  input  logic [tcw_pkg::COLOR_W-1:0]  cell_color,
  input  logic                         cfg_wen,
  input  logic [tcw_pkg::COLOR_W-1:0]  cfg_wdata,
  output int                           fail_count,
  output int                           pending
);

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 4;
  localparam int CELLS    = COLUMNS * ROWS;

  typedef struct packed {
    logic [6:0]                  ccol;
    logic [4:0]                  crow;
    logic                        adv;
    logic [tcw_pkg::CHAR_W-1:0]  ch;
    logic [tcw_pkg::COLOR_W-1:0] rgb;
  } console_result_t;

  logic [tcw_pkg::CHAR_W-1:0]  text_mem [CELLS];
  logic [tcw_pkg::COLOR_W-1:0] tint_mem [CELLS];
  int                          crs_col;
  int                          crs_row;
  logic [tcw_pkg::COLOR_W-1:0] fill_rgb;
  console_result_t             result_q [$];

  function automatic int cell_addr(int c, int r);
    return (r >= ROWS ? ROWS - 1 : r) * COLUMNS + (c >= COLUMNS ? COLUMNS - 1 : c);
  endfunction

  // next row; on the bottom row the screen shifts up and the bottom row is refilled
  function automatic void line_feed();
    int i;
    if (crs_row >= ROWS - 1) begin
      for (i = 0; i < CELLS - COLUMNS; i++) begin
        text_mem[i] = text_mem[i + COLUMNS];
        tint_mem[i] = tint_mem[i + COLUMNS];
      end
      for (i = CELLS - COLUMNS; i < CELLS; i++) begin
        text_mem[i] = '0;
        tint_mem[i] = fill_rgb;
      end
      crs_row = ROWS - 1;
    end else begin
      crs_row++;
    end
    crs_col = 0;
  endfunction

  function automatic console_result_t predict_word(tcw_pkg::cmd_t op,
                                                   logic [tcw_pkg::CHAR_W-1:0] ch,
                                                   logic [tcw_pkg::COLOR_W-1:0] rgb,
                                                   logic [6:0] cx, logic [4:0] ry);
    console_result_t r;
    int addr;
    int stop;
    r = '0;
    case (op)
      tcw_pkg::CMD_PUT_CHAR: begin
        if (ch == tcw_pkg::CODE_NL) begin
          line_feed();
          r.adv = 1'b1;
        end else if (ch == tcw_pkg::CODE_TAB) begin
          stop = (crs_col / TAB_STOP + 1) * TAB_STOP;
          if (stop >= COLUMNS) begin
            line_feed();
            r.adv = 1'b1;
          end else begin
            crs_col = stop;
          end
        end else if (ch == tcw_pkg::CODE_CR) begin
          crs_col = 0;
        end else if (ch == tcw_pkg::CODE_BS) begin
          if (crs_col > 0) begin
            crs_col--;
            text_mem[cell_addr(crs_col, crs_row)] = '0;
          end
        end else begin
          addr = cell_addr(crs_col, crs_row);
          text_mem[addr] = ch;
          tint_mem[addr] = rgb;
          crs_col++;
          if (crs_col >= COLUMNS) begin
            line_feed();
            r.adv = 1'b1;
          end
        end
      end
      tcw_pkg::CMD_CLEAR: begin
        // colors survive a clear
        for (addr = 0; addr < CELLS; addr++) text_mem[addr] = '0;
        crs_col = 0;
        crs_row = 0;
      end
      tcw_pkg::CMD_READ: begin
        addr = cell_addr(cx, ry);
        r.ch  = text_mem[addr];
        r.rgb = tint_mem[addr];
      end
      default: begin
        crs_col = (cx >= COLUMNS) ? COLUMNS - 1 : cx;
        crs_row = (ry >= ROWS) ? ROWS - 1 : ry;
      end
    endcase
    r.ccol = crs_col[6:0];
    r.crow = crs_row[4:0];
    return r;
  endfunction

  task automatic report_error(string msg);
    $display("[%0t] tcw_checker: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    console_result_t want;
    int i;
    if (rst) begin
      for (i = 0; i < CELLS; i++) begin
        text_mem[i] = '0;
        tint_mem[i] = tcw_pkg::FILL_RESET;
      end
      crs_col  = 0;
      crs_row  = 0;
      fill_rgb = tcw_pkg::FILL_RESET;
      result_q.delete();
    end else begin
      if (cfg_wen) fill_rgb = cfg_wdata;
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report_error($sformatf("result word at cursor %0d,%0d with none expected",
                                 cursor_col, cursor_row));
        end else begin
          want = result_q.pop_front();
          if (cursor_col !== want.ccol)
            report_error($sformatf("cursor_col got %0d expected %0d", cursor_col, want.ccol));
          if (cursor_row !== want.crow)
            report_error($sformatf("cursor_row got %0d expected %0d", cursor_row, want.crow));
          if (line_advanced !== want.adv)
            report_error($sformatf("line_advanced got %0b expected %0b",
                                   line_advanced, want.adv));
          if (cell_char !== want.ch)
            report_error($sformatf("cell_char got %02h expected %02h", cell_char, want.ch));
          if (cell_color !== want.rgb)
            report_error($sformatf("cell_color got %06h expected %06h",
                                   cell_color, want.rgb));
        end
      end
      if (in_valid && in_ready)
        result_q.push_back(predict_word(tcw_pkg::cmd_t'(cmd), char_code, color, col, row));
    end
    pending <= result_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the text console testbench: clock, reset, stimulus, flow control and verdict.
module tb_top;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  cmd = tcw_pkg::CMD_PUT_CHAR;
  logic [tcw_pkg::CHAR_W-1:0]  char_code = '0;
  logic [tcw_pkg::COLOR_W-1:0] color = '0;
  logic [6:0]                  col = '0;
  logic [4:0]                  row = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [6:0]                  cursor_col;
  logic [4:0]                  cursor_row;
  logic                        line_advanced;
  logic [tcw_pkg::CHAR_W-1:0]  cell_char;
  logic [tcw_pkg::COLOR_W-1:0] cell_color;
  logic                        cfg_wen = 1'b0;
  logic [tcw_pkg::COLOR_W-1:0] cfg_wdata = '0;
  int                          fail_count;
  int                          pending;
  int                          sim_phase = 0;

  text_console_cell_writer DUT (.*);

  tcw_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one word on the input channel; called at a rising edge, returns at the accepting edge
  task automatic send_word(tcw_pkg::cmd_t op, logic [tcw_pkg::CHAR_W-1:0] ch,
                           logic [tcw_pkg::COLOR_W-1:0] rgb,
                           logic [6:0] cx, logic [4:0] ry);
    int idle_pct;
    idle_pct = (sim_phase == 0) ? 33 : (sim_phase == 1) ? 81 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    char_code <= ch;
    color     <= rgb;
    col       <= cx;
    row       <= ry;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_fill(logic [tcw_pkg::COLOR_W-1:0] rgb);
    cfg_wen   <= 1'b1;
    cfg_wdata <= rgb;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // mostly text bursts near the right and bottom edges so wraps and scrolls happen often
  task automatic send_random_word();
    int pick;
    logic [6:0] cx;
    logic [4:0] ry;
    logic [tcw_pkg::CHAR_W-1:0] ctl;
    pick = $urandom_range(99);
    if (pick < 60) begin
      send_word(tcw_pkg::CMD_PUT_CHAR, 8'($urandom_range(255)),
                24'($urandom_range(24'hFFFFFF)), 7'($urandom_range(127)),
                5'($urandom_range(31)));
    end else if (pick < 72) begin
      case ($urandom_range(3))
        0:       ctl = tcw_pkg::CODE_NL;
        1:       ctl = tcw_pkg::CODE_TAB;
        2:       ctl = tcw_pkg::CODE_CR;
        default: ctl = tcw_pkg::CODE_BS;
      endcase
      send_word(tcw_pkg::CMD_PUT_CHAR, ctl, 24'($urandom_range(24'hFFFFFF)),
                7'($urandom_range(127)), 5'($urandom_range(31)));
    end else if (pick < 84) begin
      cx = ($urandom_range(1) != 0) ? 7'($urandom_range(127)) : 7'($urandom_range(79));
      ry = ($urandom_range(1) != 0) ? 5'($urandom_range(31)) : 5'($urandom_range(18, 24));
      send_word(tcw_pkg::CMD_READ, 8'($urandom_range(255)),
                24'($urandom_range(24'hFFFFFF)), cx, ry);
    end else if (pick < 98) begin
      cx = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(60, 79));
      ry = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(20, 24));
      send_word(tcw_pkg::CMD_MOVE, 8'($urandom_range(255)),
                24'($urandom_range(24'hFFFFFF)), cx, ry);
    end else begin
      send_word(tcw_pkg::CMD_CLEAR, 8'($urandom_range(255)),
                24'($urandom_range(24'hFFFFFF)), 7'($urandom_range(127)),
                5'($urandom_range(31)));
    end
  endtask

  // receiver: random stalls per phase, one long hold-off when the sender runs flat out
  initial begin
    bit hold_done;
    int idle_pct;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (sim_phase == 2 && !hold_done) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        idle_pct = (sim_phase == 0) ? 81 : (sim_phase == 1) ? 33 : 0;
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("** text_console_cell_writer: FAILED **");
    $finish;
  end

  initial begin
    int ph;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: reset contents, edges of every field, each control code, wrap and scroll
    send_word(tcw_pkg::CMD_READ,     8'h00, 24'h000000, 7'd0,   5'd0);
    send_word(tcw_pkg::CMD_PUT_CHAR, 8'h41, 24'hFFFFFF, 7'd0,   5'd0);
    send_word(tcw_pkg::CMD_PUT_CHAR, 8'h00, 24'h000000, 7'd127, 5'd31);
    send_word(tcw_pkg::CMD_PUT_CHAR, 8'hFF, 24'h123456, 7'd0,   5'd0);
    send_word(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CODE_TAB, 24'h0, 7'd0, 5'd0);
    send_word(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CODE_BS,  24'h0, 7'd0, 5'd0);
    send_word(tcw_pkg::CMD_READ,     8'h00, 24'h0, 7'd3, 5'd0);
    send_word(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CODE_CR,  24'h0, 7'd0, 5'd0);
    send_word(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CODE_BS,  24'h0, 7'd0, 5'd0);
    send_word(tcw_pkg::CMD_MOVE,     8'hFF, 24'hFFFFFF, 7'd127, 5'd31);
    send_word(tcw_pkg::CMD_READ,     8'h00, 24'h0, 7'd127, 5'd31);
    send_word(tcw_pkg::CMD_PUT_CHAR, 8'h5A, 24'h00FF00, 7'd0, 5'd0);
    send_word(tcw_pkg::CMD_READ,     8'h00, 24'h0, 7'd79, 5'd23);
    send_word(tcw_pkg::CMD_READ,     8'h00, 24'h0, 7'd5,  5'd24);
    send_word(tcw_pkg::CMD_MOVE,     8'h00, 24'h0, 7'd76, 5'd10);
    send_word(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CODE_TAB, 24'h0, 7'd0, 5'd0);
    send_word(tcw_pkg::CMD_MOVE,     8'h00, 24'h0, 7'd75, 5'd10);
    send_word(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CODE_TAB, 24'h0, 7'd0, 5'd0);
    send_word(tcw_pkg::CMD_MOVE,     8'h00, 24'h0, 7'd3,  5'd24);
    send_word(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CODE_NL,  24'h0, 7'd0, 5'd0);
    send_word(tcw_pkg::CMD_MOVE,     8'h00, 24'h0, 7'd77, 5'd24);
    send_word(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CODE_TAB, 24'h0, 7'd0, 5'd0);
    send_word(tcw_pkg::CMD_READ,     8'h00, 24'h0, 7'd80, 5'd0);
    send_word(tcw_pkg::CMD_CLEAR,    8'hFF, 24'hFFFFFF, 7'd127, 5'd31);
    send_word(tcw_pkg::CMD_READ,     8'h00, 24'h0, 7'd0, 5'd22);

    for (ph = 0; ph < 3; ph++) begin
      settle();
      case (ph)
        0:       write_fill(24'hFFFFFF);
        1:       write_fill(24'h000000);
        default: write_fill(24'($urandom_range(24'hFFFFFF)));
      endcase
      sim_phase <= ph;
      repeat (200) send_random_word();
    end

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("** text_console_cell_writer: PASSED **");
    else
      $display("** text_console_cell_writer: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/tcw_pkg.sv
src/text_console_cell_writer.sv
sim/tcw_checker.sv
sim/tb_top.sv
